// ----- hw/rtl/rcfp_pkg.sv -----
`default_nettype none
package rcfp_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int PAYLOAD_BYTES = 22;
  localparam int CH_BITS       = 11;
  localparam int ADDR_W        = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int BCNT_W        = $clog2(PAYLOAD_BYTES + 1);
  localparam int ACC_W         = CH_BITS + 7;
  localparam int CNT_W         = $clog2(ACC_W + 1);

  localparam logic [7:0] SYNC_RESET = 8'd200;
  localparam logic [7:0] FRAME_TYPE = 8'h16;
  localparam logic [7:0] CRC_POLY   = 8'hD5;
  localparam logic [7:0] FRAME_LEN  = 8'(PAYLOAD_BYTES + 2);

  typedef enum logic [2:0] {
    RX_HUNT,
    RX_LEN,
    RX_TYPE,
    RX_PAYLOAD,
    RX_CRC
  } rx_state_t;

  typedef enum logic [2:0] {
    UP_IDLE,
    UP_FILL,
    UP_MERGE,
    UP_SCALE,
    UP_MUL,
    UP_DIV,
    UP_OUT
  } up_state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  // One byte of CRC-8, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rc_channel_frame_parser_unit.sv -----
// RC channel frame parser.
// Input channel: in_valid / in_stall / rx_byte, one received serial byte per
// transfer. The parser hunts for sync_address, then takes length, type (0x16),
// 22 payload bytes and a CRC-8 byte (poly 0xD5, seed 0, over type and payload).
// Output channel: out_valid / out_stall with channel_index, channel_value
// (signed Q8.7) and last. A good frame (CRC match, length 24) yields sixteen
// transfers, last set on the sixteenth; a bad frame yields nothing.
// Throughput: one input byte per cycle while the parser is receiving. After a
// good CRC byte the input stalls while the unpacker walks the payload memory:
// each payload byte is read (fill, merge) and each channel passes check, scale,
// multiply, divide and output.
// An output stall holds the result register and the unpacker; the input stays
// stalled until the last channel has been transferred.
// Reset (rst, synchronous) returns to hunting, clears the sync address to 200
// and the output valid. Write cfg_data with cfg_write only while idle.
`default_nettype none
module rc_channel_frame_parser_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_write,
  input  wire logic [7:0]   cfg_data,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   rx_byte,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [3:0]        channel_index,
  output logic signed [15:0] channel_value,
  output logic              last
);

  logic [7:0]        sync_address;
  logic              byte_take;
  logic              start;
  logic              busy;
  rcfp_pkg::ram_wr_t wr;
  rcfp_pkg::ram_rd_t rd;
  logic [7:0]        rd_data;

  // hold the sync address register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_address <= rcfp_pkg::SYNC_RESET;
    end else if (cfg_write) begin
      sync_address <= cfg_data;
    end
  end

  // stall input while a frame is being unpacked
  assign in_stall  = busy;
  assign byte_take = in_valid && !busy;

  rcfp_frame_rx u_rx (
    .clk          (clk),
    .rst          (rst),
    .byte_take    (byte_take),
    .rx_byte      (rx_byte),
    .sync_address (sync_address),
    .wr           (wr),
    .start        (start)
  );

  rcfp_payload_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  rcfp_unpack u_unpack (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .rd            (rd),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last          (last)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/rcfp_payload_ram.sv -----
`default_nettype none
module rcfp_payload_ram (
  input  wire logic             clk,
  input  wire rcfp_pkg::ram_wr_t wr,
  input  wire rcfp_pkg::ram_rd_t rd,
  output logic [7:0]            rd_data
);

  logic [7:0] mem [rcfp_pkg::PAYLOAD_BYTES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rcfp_frame_rx.sv -----
`default_nettype none
module rcfp_frame_rx (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             byte_take,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [7:0]       sync_address,
  output rcfp_pkg::ram_wr_t     wr,
  output logic                  start
);

  rcfp_pkg::rx_state_t state, state_next;
  logic [7:0]                  length_byte;
  logic [7:0]                  crc;
  logic [rcfp_pkg::ADDR_W-1:0] pay_idx;
  logic                        pay_last;

  assign pay_last = (pay_idx == rcfp_pkg::ADDR_W'(rcfp_pkg::PAYLOAD_BYTES - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      rcfp_pkg::RX_HUNT: begin
        if (byte_take && rx_byte == sync_address) state_next = rcfp_pkg::RX_LEN;
      end
      rcfp_pkg::RX_LEN: begin
        if (byte_take) state_next = rcfp_pkg::RX_TYPE;
      end
      rcfp_pkg::RX_TYPE: begin
        if (byte_take) begin
          state_next = (rx_byte == rcfp_pkg::FRAME_TYPE) ? rcfp_pkg::RX_PAYLOAD
                                                         : rcfp_pkg::RX_HUNT;
        end
      end
      rcfp_pkg::RX_PAYLOAD: begin
        if (byte_take && pay_last) state_next = rcfp_pkg::RX_CRC;
      end
      rcfp_pkg::RX_CRC: begin
        if (byte_take) state_next = rcfp_pkg::RX_HUNT;
      end
      default: state_next = rcfp_pkg::RX_HUNT;
    endcase
  end

  always_comb begin
    wr.we   = byte_take && (state == rcfp_pkg::RX_PAYLOAD);
    wr.addr = pay_idx;
    wr.data = rx_byte;
    start   = byte_take && (state == rcfp_pkg::RX_CRC) && (rx_byte == crc)
              && (length_byte == rcfp_pkg::FRAME_LEN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rcfp_pkg::RX_HUNT;
      length_byte <= '0;
      crc         <= '0;
      pay_idx     <= '0;
    end else begin
      state <= state_next;
      if (byte_take) begin
        unique case (state)
          rcfp_pkg::RX_LEN: length_byte <= rx_byte;
          rcfp_pkg::RX_TYPE: begin
            crc     <= rcfp_pkg::crc8_step(8'h00, rx_byte);
            pay_idx <= '0;
          end
          rcfp_pkg::RX_PAYLOAD: begin
            crc     <= rcfp_pkg::crc8_step(crc, rx_byte);
            pay_idx <= pay_idx + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rcfp_unpack.sv -----
`default_nettype none
module rcfp_unpack (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  output rcfp_pkg::ram_rd_t rd,
  input  wire logic [7:0]   rd_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [3:0]        channel_index,
  output logic signed [15:0] channel_value,
  output logic              last
);

  localparam logic [rcfp_pkg::CNT_W-1:0] CNT_CH   = rcfp_pkg::CNT_W'(rcfp_pkg::CH_BITS);
  localparam logic [rcfp_pkg::CNT_W-1:0] CNT_BYTE = rcfp_pkg::CNT_W'(8);
  localparam logic [rcfp_pkg::BCNT_W-1:0] BYTES_END =
    rcfp_pkg::BCNT_W'(rcfp_pkg::PAYLOAD_BYTES);
  localparam logic [3:0] CH_LAST = 4'(rcfp_pkg::CHANNEL_COUNT - 1);

  rcfp_pkg::up_state_t state, state_next;

  logic [rcfp_pkg::ACC_W-1:0]  acc;
  logic [rcfp_pkg::CNT_W-1:0]  cnt;
  logic [rcfp_pkg::BCNT_W-1:0] byte_idx;
  logic [3:0]                  ch_idx;
  logic                        have_ch;
  logic                        bytes_left;
  logic                        xfer;

  logic                        neg;
  logic [10:0]                 mag;
  logic [14:0]                 x25;

  // Scale arithmetic
  logic signed [14:0] m5;
  logic signed [14:0] d8;
  logic signed [11:0] v;
  logic [5:0]         t;
  logic [14:0]        r;
  logic [5:0]         quo;
  logic [14:0]        mag_q;
  logic [rcfp_pkg::ACC_W-1:0] merged;

  assign have_ch    = (cnt >= CNT_CH);
  assign bytes_left = (byte_idx < BYTES_END);
  assign xfer       = out_valid && !out_stall;

  always_comb begin
    m5 = (15'($signed({4'b0, acc[10:0]})) - 15'sd992) * 15'sd5;
    d8 = (m5 < 0) ? ((m5 + 15'sd7) >>> 3) : (m5 >>> 3);
    v  = 12'(d8 + 15'sd511);
    // x/511 lies in {x/512, x/512 + 1} for the range in use
    t     = x25[14:9];
    r     = x25 - ({t, 9'b0} - 15'(t));
    quo   = t + 6'(r >= 15'd511);
    mag_q = x25 + 15'(quo);
    merged = acc | ({(rcfp_pkg::ACC_W - 8)'(0), rd_data} << cnt);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rcfp_pkg::UP_IDLE:  if (start) state_next = rcfp_pkg::UP_FILL;
      rcfp_pkg::UP_FILL: begin
        if (have_ch) state_next = rcfp_pkg::UP_SCALE;
        else if (bytes_left) state_next = rcfp_pkg::UP_MERGE;
      end
      rcfp_pkg::UP_MERGE: state_next = rcfp_pkg::UP_FILL;
      rcfp_pkg::UP_SCALE: state_next = rcfp_pkg::UP_MUL;
      rcfp_pkg::UP_MUL:   state_next = rcfp_pkg::UP_DIV;
      rcfp_pkg::UP_DIV:   state_next = rcfp_pkg::UP_OUT;
      rcfp_pkg::UP_OUT: begin
        if (xfer) state_next = last ? rcfp_pkg::UP_IDLE : rcfp_pkg::UP_FILL;
      end
      default: state_next = rcfp_pkg::UP_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state != rcfp_pkg::UP_IDLE);
    rd.re   = (state == rcfp_pkg::UP_FILL) && !have_ch && bytes_left;
    rd.addr = byte_idx[rcfp_pkg::ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcfp_pkg::UP_IDLE;
      out_valid <= 1'b0;
      ch_idx    <= '0;
      cnt       <= '0;
      byte_idx  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        rcfp_pkg::UP_IDLE: begin
          acc      <= '0;
          cnt      <= '0;
          byte_idx <= '0;
          ch_idx   <= '0;
        end
        rcfp_pkg::UP_FILL: begin
          // past the stored payload: feed zero bits
          if (!have_ch && !bytes_left) cnt <= cnt + CNT_BYTE;
        end
        rcfp_pkg::UP_MERGE: begin
          acc      <= merged;
          cnt      <= cnt + CNT_BYTE;
          byte_idx <= byte_idx + 1'b1;
        end
        rcfp_pkg::UP_SCALE: begin
          neg <= v[11];
          mag <= v[11] ? 11'(-v) : v[10:0];
          acc <= acc >> rcfp_pkg::CH_BITS;
          cnt <= cnt - CNT_CH;
        end
        rcfp_pkg::UP_MUL: begin
          x25 <= {mag, 4'b0} + {1'b0, mag, 3'b0} + 15'(mag);
        end
        rcfp_pkg::UP_DIV: begin
          out_valid     <= 1'b1;
          channel_index <= ch_idx;
          last          <= (ch_idx == CH_LAST);
          channel_value <= neg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
        end
        rcfp_pkg::UP_OUT: begin
          if (xfer) begin
            out_valid <= 1'b0;
            ch_idx    <= ch_idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
